### rtl/bmd_pkg.sv
// bmd_pkg: shared constants, codes and types of the binary mask denoise block
// used by every file of the block; depends on nothing
`default_nettype none

package bmd_pkg;

  // frame store geometry
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;

  // field widths
  localparam int COL_W      = 6;
  localparam int ROW_W      = 6;
  localparam int DIM_W      = 7;
  localparam int CHAN_W     = 8;
  localparam int RGB_W      = 24;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // smallest region side
  localparam int MIN_SIDE = 3;

  // majority thresholds on the eight neighbors
  localparam int KEEP_BLACK_MIN = 2;
  localparam int TURN_BLACK_MIN = 7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_IN_USE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_IN_USE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RED_LIMIT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_LIMIT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND    = 3'd5;

  // configuration reset values
  localparam logic [DIM_W-1:0]  RST_WIDTH_IN_USE  = 7'd64;
  localparam logic [DIM_W-1:0]  RST_HEIGHT_IN_USE = 7'd64;
  localparam logic [CHAN_W-1:0] RST_RED_LIMIT     = 8'd120;
  localparam logic [CHAN_W-1:0] RST_GREEN_LIMIT   = 8'd120;
  localparam logic [CHAN_W-1:0] RST_BLUE_LIMIT    = 8'd100;
  localparam logic [RGB_W-1:0]  RST_BACKGROUND    = 24'd0;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_SMOOTH = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  // datapath operations issued by the controller, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLR_START,
    OP_CLR_STEP,
    OP_CLR_DONE,
    OP_WRITE,
    OP_READ_ADDR,
    OP_READ_DONE,
    OP_SM_START,
    OP_SM_RD1,
    OP_SM_RD2,
    OP_SM_RIGHT,
    OP_SM_ROW,
    OP_SM_WB,
    OP_SM_LAST,
    OP_SCAN,
    OP_BOX_DONE
  } micro_op_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLR,
    S_CLR_DONE,
    S_READ,
    S_SM_RD1,
    S_SM_RD2,
    S_SM_RIGHT,
    S_SM_ROW,
    S_SM_WB,
    S_SM_LAST,
    S_SCAN,
    S_BOX_DONE
  } state_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } bmd_item_t;

  typedef struct packed {
    logic             pixel_black;
    logic [DIM_W-1:0] box_min_col;
    logic [COL_W-1:0] box_max_col;
    logic [DIM_W-1:0] box_min_row;
    logic [ROW_W-1:0] box_max_row;
  } bmd_result_t;

  // controller to datapath
  typedef struct packed {
    micro_op_t op;
  } bmd_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic res_free;
    logic clr_last;
    logic row_last;
    logic col_last;
    logic scan_last;
  } bmd_stat_t;

endpackage

`default_nettype wire

### rtl/bmd_req_if.sv
// bmd_req_if: command channel of the denoise block, valid/ready with item fields
// depends on bmd_pkg
`default_nettype none

interface bmd_req_if;
  import bmd_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, cmd, col, row, red, green, blue, input ready);
  modport sink   (input valid, cmd, col, row, red, green, blue, output ready);
endinterface

`default_nettype wire

### rtl/bmd_rsp_if.sv
// bmd_rsp_if: result channel of the denoise block, valid/ready with result fields
// depends on bmd_pkg
`default_nettype none

interface bmd_rsp_if;
  import bmd_pkg::*;

  logic             valid;
  logic             ready;
  logic             pixel_black;
  logic [DIM_W-1:0] box_min_col;
  logic [COL_W-1:0] box_max_col;
  logic [DIM_W-1:0] box_min_row;
  logic [ROW_W-1:0] box_max_row;

  modport source (output valid, pixel_black, box_min_col, box_max_col, box_min_row,
                  box_max_row, input ready);
  modport sink   (input valid, pixel_black, box_min_col, box_max_col, box_min_row,
                  box_max_row, output ready);
endinterface

`default_nettype wire

### rtl/binary_mask_denoise_3x3.sv
// binary_mask_denoise_3x3: top level, binds controller, datapath and output register
// depends on bmd_pkg, bmd_req_if, bmd_rsp_if, bmd_ctrl, bmd_dp
//
//   channel  dir  handshake      beat contents
//   req      in   valid/ready    cmd, col, row, red, green, blue
//   rsp      out  valid/ready    pixel_black, box_min_col/max_col, box_min_row/max_row
//   cfg      in   cfg_we only    cfg_index selects register, cfg_data holds value
//
// steps per command beat, from acceptance to the result register:
//   write loads the result on acceptance, read goes through the registered frame store read,
//   clear writes one column word a cycle, smooth sweeps the region in use (one row of the 3x3 update a cycle)
// the result then passes from the result register into the output register
// reset runs a clearing pass over all 64 columns of the frame store; req is held off meanwhile
// a result waiting on rsp does not stall req until a second result is ready
`default_nettype none

module binary_mask_denoise_3x3 (
  input  logic                            clk,
  input  logic                            rst,
  bmd_req_if.sink                         req,
  bmd_rsp_if.source                       rsp,
  input  logic                            cfg_we,
  input  logic [bmd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bmd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bmd_pkg::*;

  bmd_ctl_t    ctl;
  bmd_stat_t   stat;
  bmd_item_t   item;
  bmd_result_t res;
  logic        res_full;
  logic        res_take;

  // output register
  logic        out_valid;
  bmd_result_t out_data;

  // pack the command beat
  assign item.cmd   = cmd_t'(req.cmd);
  assign item.col   = req.col;
  assign item.row   = req.row;
  assign item.red   = req.red;
  assign item.green = req.green;
  assign item.blue  = req.blue;

  bmd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_cmd   (item.cmd),
    .stat     (stat),
    .in_ready (req.ready),
    .ctl      (ctl)
  );

  bmd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_take  (res_take),
    .stat      (stat),
    .res       (res),
    .res_full  (res_full)
  );

  // move the result forward whenever the output register is empty or draining
  assign res_take = res_full && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || rsp.ready) begin
      out_valid <= res_full;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data <= res;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.pixel_black = out_data.pixel_black;
  assign rsp.box_min_col = out_data.box_min_col;
  assign rsp.box_max_col = out_data.box_max_col;
  assign rsp.box_min_row = out_data.box_min_row;
  assign rsp.box_max_row = out_data.box_max_row;

endmodule

`default_nettype wire

### rtl/bmd_ctrl.sv
// bmd_ctrl: sequencer of the denoise block, issues one datapath operation a cycle
// depends on bmd_pkg
`default_nettype none

module bmd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  bmd_pkg::cmd_t      in_cmd,
  input  bmd_pkg::bmd_stat_t stat,
  output logic               in_ready,
  output bmd_pkg::bmd_ctl_t  ctl
);
  import bmd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl.op     = OP_NONE;
    in_ready   = 1'b0;
    unique case (state)
      S_INIT: begin
        // clearing pass after reset
        ctl.op = OP_CLR_STEP;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = stat.res_free;
        if (in_valid && stat.res_free) begin
          unique case (in_cmd)
            CMD_CLEAR: begin
              ctl.op     = OP_CLR_START;
              state_next = S_CLR;
            end
            CMD_WRITE: begin
              ctl.op = OP_WRITE;
            end
            CMD_SMOOTH: begin
              ctl.op     = OP_SM_START;
              state_next = S_SM_RD1;
            end
            CMD_READ: begin
              ctl.op     = OP_READ_ADDR;
              state_next = S_READ;
            end
          endcase
        end
      end
      S_CLR: begin
        ctl.op = OP_CLR_STEP;
        if (stat.clr_last) state_next = S_CLR_DONE;
      end
      S_CLR_DONE: begin
        ctl.op     = OP_CLR_DONE;
        state_next = S_IDLE;
      end
      S_READ: begin
        ctl.op     = OP_READ_DONE;
        state_next = S_IDLE;
      end
      S_SM_RD1: begin
        ctl.op     = OP_SM_RD1;
        state_next = S_SM_RD2;
      end
      S_SM_RD2: begin
        ctl.op     = OP_SM_RD2;
        state_next = S_SM_RIGHT;
      end
      S_SM_RIGHT: begin
        ctl.op     = OP_SM_RIGHT;
        state_next = S_SM_ROW;
      end
      S_SM_ROW: begin
        ctl.op = OP_SM_ROW;
        if (stat.row_last) state_next = S_SM_WB;
      end
      S_SM_WB: begin
        ctl.op     = OP_SM_WB;
        state_next = stat.col_last ? S_SM_LAST : S_SM_RIGHT;
      end
      S_SM_LAST: begin
        ctl.op     = OP_SM_LAST;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        ctl.op = OP_SCAN;
        if (stat.scan_last) state_next = S_BOX_DONE;
      end
      S_BOX_DONE: begin
        ctl.op     = OP_BOX_DONE;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/bmd_dp.sv
// bmd_dp: frame store, column window, 3x3 majority update, bounding box and result register
// depends on bmd_pkg; driven by bmd_ctrl operations
`default_nettype none

module bmd_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  bmd_pkg::bmd_ctl_t               ctl,
  input  bmd_pkg::bmd_item_t              item,
  input  logic                            cfg_we,
  input  logic [bmd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bmd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            res_take,
  output bmd_pkg::bmd_stat_t              stat,
  output bmd_pkg::bmd_result_t            res,
  output logic                            res_full
);
  import bmd_pkg::*;

  // configuration
  logic [DIM_W-1:0]  width_in_use;
  logic [DIM_W-1:0]  height_in_use;
  logic [CHAN_W-1:0] red_limit;
  logic [CHAN_W-1:0] green_limit;
  logic [CHAN_W-1:0] blue_limit;
  logic [RGB_W-1:0]  background_colour;

  // frame store, one word per column, one bit per row
  logic [MAX_HEIGHT-1:0] mem [MAX_WIDTH];
  logic [MAX_HEIGHT-1:0] rd_data;
  logic [COL_W-1:0]      rd_addr;
  logic                  wr_en;
  logic [COL_W-1:0]      wr_addr;
  logic [MAX_HEIGHT-1:0] wr_mask;
  logic [MAX_HEIGHT-1:0] wr_data;

  // sweep state
  logic [COL_W-1:0]      c;
  logic [ROW_W-1:0]      r;
  logic [MAX_HEIGHT-1:0] left;
  logic [MAX_HEIGHT-1:0] cur;
  logic [MAX_HEIGHT-1:0] right;
  logic [ROW_W-1:0]      rd_row;
  logic                  rd_ok;

  // bounding box
  logic [DIM_W-1:0]      min_c;
  logic [COL_W-1:0]      max_c;
  logic                  col_found;
  logic [DIM_W-1:0]      min_r;
  logic [ROW_W-1:0]      max_r;
  logic                  row_found;
  logic [MAX_HEIGHT-1:0] row_or;

  logic [DIM_W-1:0]      w_eff;
  logic [DIM_W-1:0]      h_eff;
  logic [COL_W-1:0]      w_m2;
  logic [ROW_W-1:0]      h_m2;
  logic [ROW_W-1:0]      h_m1;
  logic                  in_range;
  logic                  pix_black;
  logic [MAX_HEIGHT-1:0] row_mask;
  logic [ROW_W-1:0]      r_dn;
  logic [ROW_W-1:0]      r_up;
  logic [3:0]            nb_black;
  logic                  new_bit;
  logic                  acc_en;
  logic [MAX_HEIGHT-1:0] acc_masked;
  logic [COL_W-1:0]      acc_col;
  logic                  res_load;
  bmd_result_t           res_next;

  // region size saturates to the legal range
  always_comb begin
    if (width_in_use < DIM_W'(MIN_SIDE)) w_eff = DIM_W'(MIN_SIDE);
    else if (width_in_use > DIM_W'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
    else w_eff = width_in_use;
    if (height_in_use < DIM_W'(MIN_SIDE)) h_eff = DIM_W'(MIN_SIDE);
    else if (height_in_use > DIM_W'(MAX_HEIGHT)) h_eff = DIM_W'(MAX_HEIGHT);
    else h_eff = height_in_use;
  end

  assign w_m2 = COL_W'(w_eff - DIM_W'(2));
  assign h_m2 = ROW_W'(h_eff - DIM_W'(2));
  assign h_m1 = ROW_W'(h_eff - DIM_W'(1));

  assign in_range = ({1'b0, item.col} < w_eff) && ({1'b0, item.row} < h_eff);

  // white when background or bright on all three channels
  assign pix_black = !(({item.red, item.green, item.blue} == background_colour) ||
                       ((item.red > red_limit) && (item.green > green_limit) &&
                        (item.blue > blue_limit)));

  always_comb begin
    for (int i = 0; i < MAX_HEIGHT; i++) begin
      row_mask[i] = (DIM_W'(i) < h_eff);
    end
  end

  // 3x3 window: left is final, cur holds updated rows above r, right is old
  assign r_dn = r - ROW_W'(1);
  assign r_up = r + ROW_W'(1);
  assign nb_black = 4'(left[r_dn]) + 4'(left[r]) + 4'(left[r_up]) +
                    4'(cur[r_dn]) + 4'(cur[r_up]) +
                    4'(right[r_dn]) + 4'(right[r]) + 4'(right[r_up]);
  // black survives with two black neighbors; anything turns black with seven
  assign new_bit = (cur[r] && (nb_black >= 4'(KEEP_BLACK_MIN))) ||
                   (nb_black >= 4'(TURN_BLACK_MIN));

  assign acc_en     = (ctl.op == OP_SM_RD2) || (ctl.op == OP_SM_WB) ||
                      (ctl.op == OP_SM_LAST);
  assign acc_masked = ((ctl.op == OP_SM_RD2) ? left : cur) & row_mask;
  assign acc_col    = (ctl.op == OP_SM_RD2) ? (c - COL_W'(1)) : c;

  // memory port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = c;
    wr_mask = '0;
    wr_data = '0;
    rd_addr = c;
    unique case (ctl.op)
      OP_CLR_STEP: begin
        wr_en   = 1'b1;
        wr_mask = '1;
      end
      OP_WRITE: begin
        wr_en            = in_range;
        wr_addr          = item.col;
        wr_mask[item.row] = 1'b1;
        wr_data          = {MAX_HEIGHT{pix_black}};
      end
      OP_SM_WB: begin
        wr_en   = 1'b1;
        wr_mask = '1;
        wr_data = cur;
        rd_addr = c + COL_W'(2);
      end
      OP_READ_ADDR: rd_addr = item.col;
      OP_SM_START:  rd_addr = '0;
      OP_SM_RD2:    rd_addr = c + COL_W'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int i = 0; i < MAX_HEIGHT; i++) begin
        if (wr_mask[i]) mem[wr_addr][i] <= wr_data[i];
      end
    end
    rd_data <= mem[rd_addr];
  end

  // column and row counters
  always_ff @(posedge clk) begin
    if (rst) begin
      c <= '0;
      r <= '0;
    end else begin
      unique case (ctl.op)
        OP_CLR_START: c <= '0;
        OP_CLR_STEP:  c <= c + COL_W'(1);
        OP_SM_START:  c <= COL_W'(1);
        OP_SM_RIGHT:  r <= ROW_W'(1);
        OP_SM_ROW:    r <= r + ROW_W'(1);
        OP_SM_WB:     c <= c + COL_W'(1);
        OP_SM_LAST:   r <= '0;
        OP_SCAN:      r <= r + ROW_W'(1);
        default: ;
      endcase
    end
  end

  // column window and read capture
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_READ_ADDR: begin
        rd_row <= item.row;
        rd_ok  <= in_range;
      end
      OP_SM_RD1:   left  <= rd_data;
      OP_SM_RD2:   cur   <= rd_data;
      OP_SM_RIGHT: right <= rd_data;
      OP_SM_ROW:   cur[r] <= new_bit;
      OP_SM_WB: begin
        left <= cur;
        cur  <= right;
      end
      default: ;
    endcase
  end

  // box: columns as their final words pass, rows by a scan of the row union
  always_ff @(posedge clk) begin
    if (ctl.op == OP_SM_START) begin
      min_c     <= w_eff;
      max_c     <= '0;
      col_found <= 1'b0;
      min_r     <= h_eff;
      max_r     <= '0;
      row_found <= 1'b0;
      row_or    <= '0;
    end else if (acc_en && (|acc_masked)) begin
      if (!col_found) min_c <= {1'b0, acc_col};
      max_c     <= acc_col;
      col_found <= 1'b1;
      row_or    <= row_or | acc_masked;
    end else if ((ctl.op == OP_SCAN) && row_or[r]) begin
      if (!row_found) min_r <= {1'b0, r};
      max_r     <= r;
      row_found <= 1'b1;
    end
  end

  // result register
  assign res_load = (ctl.op == OP_CLR_DONE) || (ctl.op == OP_WRITE) ||
                    (ctl.op == OP_READ_DONE) || (ctl.op == OP_BOX_DONE);

  // only read reports a pixel, only smooth reports a box
  always_comb begin
    res_next = '0;
    if (ctl.op == OP_READ_DONE) begin
      res_next.pixel_black = rd_ok && rd_data[rd_row];
    end
    if (ctl.op == OP_BOX_DONE) begin
      res_next.box_min_col = min_c;
      res_next.box_max_col = max_c;
      res_next.box_min_row = min_r;
      res_next.box_max_row = max_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_full <= 1'b0;
    end else begin
      res_full <= res_load || (res_full && !res_take);
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      width_in_use      <= RST_WIDTH_IN_USE;
      height_in_use     <= RST_HEIGHT_IN_USE;
      red_limit         <= RST_RED_LIMIT;
      green_limit       <= RST_GREEN_LIMIT;
      blue_limit        <= RST_BLUE_LIMIT;
      background_colour <= RST_BACKGROUND;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH_IN_USE:  width_in_use      <= cfg_data[DIM_W-1:0];
        REG_HEIGHT_IN_USE: height_in_use     <= cfg_data[DIM_W-1:0];
        REG_RED_LIMIT:     red_limit         <= cfg_data[CHAN_W-1:0];
        REG_GREEN_LIMIT:   green_limit       <= cfg_data[CHAN_W-1:0];
        REG_BLUE_LIMIT:    blue_limit        <= cfg_data[CHAN_W-1:0];
        REG_BACKGROUND:    background_colour <= cfg_data[RGB_W-1:0];
        default: ;
      endcase
    end
  end

  assign stat.res_free  = !res_full || res_take;
  assign stat.clr_last  = (c == COL_W'(MAX_WIDTH - 1));
  assign stat.row_last  = (r == h_m2);
  assign stat.col_last  = (c == w_m2);
  assign stat.scan_last = (r == h_m1);

`ifndef SYNTHESIS
  a_res_no_overrun: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!res_full || res_take))
    else $error("result register loaded while still full");

  a_row_interior: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == OP_SM_ROW) |-> ((r >= ROW_W'(1)) && (r <= h_m2)))
    else $error("smoothing row outside the interior");

  a_col_interior: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == OP_SM_WB) |-> ((c >= COL_W'(1)) && (c <= w_m2)))
    else $error("write-back column outside the interior");

  a_box_consistent: assert property (@(posedge clk) disable iff (rst)
    ((ctl.op == OP_BOX_DONE) && col_found) |-> (row_found && (min_c <= {1'b0, max_c})))
    else $error("bounding box columns and rows disagree");

  a_write_result: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == OP_WRITE) |=> res_full)
    else $error("pixel write gave no result");
`endif

endmodule

`default_nettype wire
